/* design/wsrm_pkg.sv */
// Shared types, symbol codes and helpers for the wildcard star regex matcher.
// No dependencies; compiled before every other file of the block.

package wsrm_pkg;

   localparam int SYMBOL_W            = 8;
   localparam int PATTERN_MAX_DEFAULT = 32;

   localparam logic [SYMBOL_W-1:0] SYM_STAR = 8'h2A;
   localparam logic [SYMBOL_W-1:0] SYM_DOT  = 8'h2E;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_RESTART = 2'd2,
      CMD_TEXT    = 2'd3
   } cmd_type;

   typedef logic [SYMBOL_W-1:0] symbol_type;

   typedef struct packed {
      logic       fire;
      cmd_type    op;
      symbol_type symbol;
      logic       append_here;
      logic       active;
   } cell_ctrl_type;

   typedef struct packed {
      logic       has_prev;
      logic       m_prev;
      symbol_type pat_prev;
      logic       next_prev2;
      logic       e_prev2;
   } cell_nbr_type;

   typedef struct packed {
      symbol_type pat;
      logic       e;
      logic       m;
      logic       text_bit;
      logic       m_in;
   } cell_out_type;

   function automatic logic sym_hits(input symbol_type text_sym, input symbol_type pat_sym);
      return (text_sym == pat_sym) || (pat_sym == SYM_DOT);
   endfunction

endpackage

/* design/wsrm_if.sv */
// Valid/ready channel interfaces for the request and response sides of the matcher.
// Depends on wsrm_pkg.

interface wsrm_req_if import wsrm_pkg::*; ();
   logic       valid;
   logic       ready;
   cmd_type    command;
   symbol_type symbol;

   modport source (output valid, output command, output symbol, input ready);
   modport sink   (input valid, input command, input symbol, output ready);
endinterface

interface wsrm_rsp_if import wsrm_pkg::*; ();
   logic valid;
   logic ready;
   logic matched;
   logic pattern_overflow;

   modport source (output valid, output matched, output pattern_overflow, input ready);
   modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

/* design/wildcard_star_regex_matcher.sv */
// Whole-string matcher for '.' and '*' patterns: one result transfer for every request
// transfer, built from a row of wsrm_cell instances. Depends on wsrm_pkg and wsrm_if.
//
// The whole match row is updated at the clock edge that accepts a request, with the star terms
// rippling combinationally along the row of cells, and the result sits in an output register
// while the next request is taken. Clear, append
// (which also restarts the text), restart and text-symbol commands all give one result:
// whether the text so far matches the whole pattern, and whether an append found the
// pattern store full. No clearing pass is needed after reset.

module wildcard_star_regex_matcher import wsrm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   wsrm_req_if.sink     req_chan,
   wsrm_rsp_if.source   rsp_chan
);

   localparam int CNT_W = $clog2(PATTERN_MAX + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             m0_ff, m0_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             matched_ff, matched_in;
   logic             overflow_ff, overflow_in;
   logic             fire;
   logic             full;
   logic [PATTERN_MAX:0] row_in;

   cell_ctrl_type ctrl     [PATTERN_MAX];
   cell_nbr_type  nbr      [PATTERN_MAX];
   cell_out_type  cell_out [PATTERN_MAX];

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;
   assign full           = (count_ff == CNT_W'(PATTERN_MAX));

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      always_comb begin
         ctrl[j].fire        = fire;
         ctrl[j].op          = req_chan.command;
         ctrl[j].symbol      = req_chan.symbol;
         ctrl[j].append_here = (count_ff == CNT_W'(j));
         ctrl[j].active      = (CNT_W'(j) < count_ff);
      end

      if (j == 0) begin : g_first
         always_comb begin
            nbr[j].has_prev   = 1'b0;
            nbr[j].m_prev     = m0_ff;
            nbr[j].pat_prev   = '0;
            nbr[j].next_prev2 = 1'b0;
            nbr[j].e_prev2    = 1'b0;
         end
      end else if (j == 1) begin : g_second
         always_comb begin
            nbr[j].has_prev   = 1'b1;
            nbr[j].m_prev     = cell_out[j-1].m;
            nbr[j].pat_prev   = cell_out[j-1].pat;
            nbr[j].next_prev2 = 1'b0;
            nbr[j].e_prev2    = 1'b1;
         end
      end else begin : g_rest
         always_comb begin
            nbr[j].has_prev   = 1'b1;
            nbr[j].m_prev     = cell_out[j-1].m;
            nbr[j].pat_prev   = cell_out[j-1].pat;
            nbr[j].next_prev2 = cell_out[j-2].text_bit;
            nbr[j].e_prev2    = cell_out[j-2].e;
         end
      end

      wsrm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[j]),
         .nbr      (nbr[j]),
         .cell_out (cell_out[j])
      );

      assign row_in[j+1] = cell_out[j].m_in;
   end

   always_comb begin
      count_in    = count_ff;
      m0_in       = m0_ff;
      overflow_in = 1'b0;
      if (fire) begin
         unique case (req_chan.command)
            CMD_CLEAR: begin
               count_in = '0;
               m0_in    = 1'b1;
            end
            CMD_APPEND: begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               m0_in = 1'b1;
            end
            CMD_RESTART: begin
               m0_in = 1'b1;
            end
            CMD_TEXT: begin
               m0_in = 1'b0;
            end
            default: begin
               m0_in = m0_ff;
            end
         endcase
      end
   end

   assign row_in[0]  = m0_in;
   assign matched_in = row_in[count_in];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         m0_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         m0_ff        <= m0_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         matched_ff  <= matched_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.matched          = matched_ff;
   assign rsp_chan.pattern_overflow = overflow_ff;

endmodule

/* design/wsrm_cell.sv */
// One pattern position of the matcher: holds the pattern byte, the empty-text bit
// and the current match bit for that position. Depends on wsrm_pkg.

module wsrm_cell import wsrm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_nbr_type  nbr,
   output cell_out_type  cell_out
);

   symbol_type pat_ff, pat_in;
   logic       e_ff, e_in;
   logic       m_ff, m_in;
   logic       text_bit;
   logic       is_star;

   assign is_star = (pat_ff == SYM_STAR);

   always_comb begin
      if (!ctrl.active) begin
         text_bit = 1'b0;
      end else if (is_star) begin
         text_bit = nbr.has_prev &&
                    (nbr.next_prev2 || (sym_hits(ctrl.symbol, nbr.pat_prev) && m_ff));
      end else begin
         text_bit = sym_hits(ctrl.symbol, pat_ff) && nbr.m_prev;
      end
   end

   always_comb begin
      pat_in = pat_ff;
      e_in   = e_ff;
      m_in   = m_ff;
      if (ctrl.fire) begin
         unique case (ctrl.op)
            CMD_CLEAR: begin
               e_in = 1'b0;
               m_in = 1'b0;
            end
            CMD_APPEND: begin
               if (ctrl.append_here) begin
                  pat_in = ctrl.symbol;
                  e_in   = (ctrl.symbol == SYM_STAR) && nbr.has_prev && nbr.e_prev2;
               end
               m_in = e_in;
            end
            CMD_RESTART: begin
               m_in = e_ff;
            end
            CMD_TEXT: begin
               m_in = text_bit;
            end
            default: begin
               m_in = m_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      pat_ff <= pat_in;
      if (reset) begin
         e_ff <= 1'b0;
         m_ff <= 1'b0;
      end else begin
         e_ff <= e_in;
         m_ff <= m_in;
      end
   end

   assign cell_out.pat      = pat_ff;
   assign cell_out.e        = e_ff;
   assign cell_out.m        = m_ff;
   assign cell_out.text_bit = text_bit;
   assign cell_out.m_in     = m_in;

endmodule

/* bench/testbench.sv */
// Self-checking bench for wildcard_star_regex_matcher: directed and random command streams,
// each result checked against a row-form predictor of the '.'/'*' whole-string match.
// Depends on wsrm_pkg, wsrm_if and the matcher RTL.

module testbench import wsrm_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PATTERN_MAX = PATTERN_MAX_DEFAULT;
   localparam int ITEM_TARGET = 1550;
   localparam symbol_type SYM_A = 8'h61;
   localparam symbol_type SYM_B = 8'h62;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } match_result_type;

   logic clock = 1'b0;
   logic reset;

   wsrm_req_if req_chan ();
   wsrm_rsp_if rsp_chan ();

   wildcard_star_regex_matcher DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predictor state
   symbol_type           pattern_mem [PATTERN_MAX];
   int unsigned          pattern_len;
   logic [PATTERN_MAX:0] text_row;
   logic [PATTERN_MAX:0] empty_row;

   match_result_type match_expect_q[$];
   int unsigned      sent_count;
   int unsigned      checked_count;
   int unsigned      matched_count;
   int unsigned      overflow_count;
   int unsigned      error_count;
   logic             steady;

   function automatic void clear_predictor();
      pattern_len = 0;
      empty_row   = '0;
      empty_row[0] = 1'b1;
      text_row    = empty_row;
   endfunction

   function automatic logic symbol_fits(input symbol_type text_sym, input symbol_type pat_sym);
      return (text_sym == pat_sym) || (pat_sym == SYM_DOT);
   endfunction

   function automatic match_result_type apply_command(input cmd_type op, input symbol_type sym);
      logic [PATTERN_MAX:0] next_row;
      match_result_type     res;
      logic                 prev_empty;
      res.pattern_overflow = 1'b0;
      case (op)
         CMD_CLEAR: begin
            clear_predictor();
         end
         CMD_APPEND: begin
            if (pattern_len >= PATTERN_MAX) begin
               res.pattern_overflow = 1'b1;
            end else begin
               prev_empty = (pattern_len >= 1) ? empty_row[pattern_len-1] : 1'b0;
               pattern_mem[pattern_len] = sym;
               empty_row[pattern_len+1] = (sym == SYM_STAR) && prev_empty;
               pattern_len++;
            end
            text_row = empty_row;
         end
         CMD_RESTART: begin
            text_row = empty_row;
         end
         default: begin
            next_row = '0;
            for (int j = 0; j < pattern_len; j++) begin
               if (pattern_mem[j] == SYM_STAR) begin
                  if (j == 0)
                     next_row[1] = 1'b0;
                  else
                     next_row[j+1] = next_row[j-1] ||
                        (symbol_fits(sym, pattern_mem[j-1]) && text_row[j+1]);
               end else begin
                  next_row[j+1] = symbol_fits(sym, pattern_mem[j]) && text_row[j];
               end
            end
            text_row = next_row;
         end
      endcase
      res.matched = text_row[pattern_len];
      return res;
   endfunction

   function automatic logic idle_now();
      return !steady && ($urandom_range(0, 99) < 15);
   endfunction

   function automatic symbol_type pick_pattern_symbol();
      case ($urandom_range(0, 9))
         0, 1:    return SYM_A;
         2:       return SYM_B;
         3:       return SYM_DOT;
         4, 5:    return SYM_STAR;
         default: return symbol_type'($urandom_range(0, 255));
      endcase
   endfunction

   // Text that the pattern should accept: each starred symbol repeated 0..3 times
   function automatic void build_text(input symbol_type pat[$], output symbol_type txt[$]);
      int unsigned i;
      symbol_type  p;
      txt = {};
      i = 0;
      while (i < pat.size()) begin
         p = pat[i];
         if (i + 1 < pat.size() && pat[i+1] == SYM_STAR) begin
            repeat ($urandom_range(0, 3))
               txt.push_back((p == SYM_DOT) ? symbol_type'($urandom_range(0, 255)) : p);
            i += 2;
         end else begin
            txt.push_back((p == SYM_DOT) ? symbol_type'($urandom_range(0, 255)) : p);
            i++;
         end
      end
   endfunction

   task automatic send_request(input cmd_type op, input symbol_type sym);
      @(negedge clock);
      while (idle_now()) begin
         req_chan.valid   = 1'b0;
         req_chan.command = cmd_type'($urandom_range(0, 3));
         req_chan.symbol  = symbol_type'($urandom_range(0, 255));
         @(negedge clock);
      end
      req_chan.valid   = 1'b1;
      req_chan.command = op;
      req_chan.symbol  = sym;
      do @(posedge clock); while (!req_chan.ready);
      match_expect_q.push_back(apply_command(op, sym));
      sent_count++;
   endtask

   always @(negedge clock) begin
      rsp_chan.ready = !idle_now();
   end

   always @(posedge clock) begin : check_results
      match_result_type exp;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (match_expect_q.size() == 0) begin
            $error("unexpected result transfer: matched %0b, pattern_overflow %0b",
                   rsp_chan.matched, rsp_chan.pattern_overflow);
            error_count++;
         end else begin
            exp = match_expect_q.pop_front();
            checked_count++;
            if (exp.matched) matched_count++;
            if (exp.pattern_overflow) overflow_count++;
            if (rsp_chan.matched !== exp.matched) begin
               $error("matched: expected %0b, actual %0b", exp.matched, rsp_chan.matched);
               error_count++;
            end
            if (rsp_chan.pattern_overflow !== exp.pattern_overflow) begin
               $error("pattern_overflow: expected %0b, actual %0b",
                      exp.pattern_overflow, rsp_chan.pattern_overflow);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_pattern();
      send_request(CMD_RESTART, 8'hFF);
      send_request(CMD_TEXT, 8'h00);
      send_request(CMD_TEXT, 8'hFF);
      send_request(CMD_RESTART, 8'h00);
      send_request(CMD_CLEAR, 8'hA5);
   endtask

   task automatic test_literals_and_dot();
      send_request(CMD_APPEND, 8'h00);
      send_request(CMD_APPEND, SYM_DOT);
      send_request(CMD_APPEND, 8'hFF);
      send_request(CMD_TEXT, 8'h00);
      send_request(CMD_TEXT, 8'h71);
      send_request(CMD_TEXT, 8'hFF);
      send_request(CMD_TEXT, 8'h00);
      send_request(CMD_RESTART, 8'h5A);
   endtask

   task automatic test_leading_star();
      send_request(CMD_CLEAR, 8'h00);
      send_request(CMD_APPEND, SYM_STAR);
      send_request(CMD_RESTART, 8'h00);
      send_request(CMD_TEXT, SYM_STAR);
   endtask

   task automatic test_star_after_star();
      send_request(CMD_CLEAR, 8'h00);
      send_request(CMD_APPEND, SYM_A);
      send_request(CMD_APPEND, SYM_STAR);
      send_request(CMD_APPEND, SYM_STAR);
      send_request(CMD_TEXT, SYM_A);
      send_request(CMD_TEXT, SYM_STAR);
      send_request(CMD_TEXT, SYM_STAR);
   endtask

   task automatic test_pattern_overflow();
      symbol_type pat[$];
      symbol_type txt[$];
      repeat (3) begin
         pat = {};
         send_request(CMD_CLEAR, symbol_type'($urandom_range(0, 255)));
         repeat (PATTERN_MAX) pat.push_back(pick_pattern_symbol());
         foreach (pat[i]) send_request(CMD_APPEND, pat[i]);
         repeat ($urandom_range(1, 2))
            send_request(CMD_APPEND, symbol_type'($urandom_range(0, 255)));
         build_text(pat, txt);
         foreach (txt[i]) send_request(CMD_TEXT, txt[i]);
      end
   endtask

   task automatic test_random_sequences(input int unsigned stop_at);
      symbol_type pat[$];
      symbol_type txt[$];
      int unsigned len;
      while (sent_count < stop_at) begin
         pat = {};
         if ($urandom_range(0, 19) != 0)
            send_request(CMD_CLEAR, symbol_type'($urandom_range(0, 255)));
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, PATTERN_MAX + 2)
                                            : $urandom_range(0, 8);
         repeat (len) pat.push_back(pick_pattern_symbol());
         foreach (pat[i]) send_request(CMD_APPEND, pat[i]);
         repeat ($urandom_range(1, 3)) begin
            build_text(pat, txt);
            if (txt.size() > 0 && $urandom_range(0, 4) == 0)
               txt[$urandom_range(0, txt.size() - 1)] = symbol_type'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
               txt.push_back(symbol_type'($urandom_range(0, 255)));
            foreach (txt[i]) send_request(CMD_TEXT, txt[i]);
            send_request(CMD_RESTART, symbol_type'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_random_noise(input int unsigned stop_at);
      while (sent_count < stop_at)
         send_request(cmd_type'($urandom_range(0, 3)), symbol_type'($urandom_range(0, 255)));
   endtask

   initial begin
      reset            = 1'b1;
      steady           = 1'b0;
      req_chan.valid   = 1'b0;
      req_chan.command = CMD_CLEAR;
      req_chan.symbol  = '0;
      rsp_chan.ready   = 1'b0;
      sent_count       = 0;
      checked_count    = 0;
      matched_count    = 0;
      overflow_count   = 0;
      error_count      = 0;
      clear_predictor();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_pattern();
      test_literals_and_dot();
      test_leading_star();
      test_star_after_star();
      test_pattern_overflow();
      test_random_sequences(700);
      steady = 1'b1;
      test_random_sequences(1000);
      steady = 1'b0;
      test_random_sequences(1400);
      test_random_noise(ITEM_TARGET);

      @(negedge clock);
      req_chan.valid = 1'b0;
      while (match_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d request transfers, %0d results checked: %0d matches, %0d overflows.",
               sent_count, checked_count, matched_count, overflow_count);
      if (error_count == 0 && match_expect_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
design/wsrm_pkg.sv
design/wsrm_if.sv
design/wsrm_cell.sv
design/wildcard_star_regex_matcher.sv
bench/testbench.sv
